FILE: src/bpa_pkg.sv
// Shared constants, operation codes and a helper for the bitmap page allocator.
package bpa_pkg;

    localparam int unsigned MAP_PAGES_DEF = 32768;

    localparam int unsigned WORD_W    = 8;
    localparam int unsigned BIT_SEL_W = 3;
    localparam logic [WORD_W-1:0] WORD_ALL_USED = 8'hFF;

    localparam int unsigned OP_W       = 2;
    localparam int unsigned PAGE_IN_W  = 40;
    localparam int unsigned TYPE_W     = 4;
    localparam int unsigned OUT_PAGE_W = 15;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_MARK  = 2'd2,
        OP_ADD   = 2'd3
    } op_t;

    localparam logic [TYPE_W-1:0] RT_LOADER_CODE  = 4'd3;
    localparam logic [TYPE_W-1:0] RT_LOADER_DATA  = 4'd4;
    localparam logic [TYPE_W-1:0] RT_CONVENTIONAL = 4'd7;

    function automatic logic is_usable(input logic [TYPE_W-1:0] kind);
        return (kind == RT_LOADER_CODE) || (kind == RT_LOADER_DATA) ||
               (kind == RT_CONVENTIONAL);
    endfunction

endpackage

FILE: src/bitmap_page_allocator_unit.sv
// Bitmap first-fit page allocator: used-page map in a byte-wide memory and a scan sequencer.
//
//   channel | ports                                                  | direction
//   --------+--------------------------------------------------------+----------
//   s_      | s_valid s_ready s_operation s_start_page s_page_count  | in
//           | s_region_type                                          |
//   m_      | m_valid m_ready m_success m_alloc_page                 | out
//
// After reset a clearing pass writes every map word as used, with s_ready low throughout.
// Free, mark used and usable add region read the first word, then rewrite each word touched.
// Alloc scans the map from word 0 up to the first free run and then marks that run used;
// a miss answers after the scan. Zero or oversized requests and empty runs go straight to the result.
// s_ready returns in the same cycle that the result loads; the map moves eight pages per cycle.
// A waiting result lets the next transfer in; finishing that item holds until it is taken.
module bitmap_page_allocator_unit
    import bpa_pkg::*;
#(
    parameter int unsigned MAP_PAGES = MAP_PAGES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OP_W-1:0]       s_operation,
    input  logic [PAGE_IN_W-1:0]  s_start_page,
    input  logic [PAGE_IN_W-1:0]  s_page_count,
    input  logic [TYPE_W-1:0]     s_region_type,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_success,
    output logic [OUT_PAGE_W-1:0] m_alloc_page
);

    localparam int unsigned NUM_WORDS = (MAP_PAGES + WORD_W - 1) / WORD_W;
    localparam int unsigned WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int unsigned PW        = WADDR_W + BIT_SEL_W + 1;
    localparam int unsigned CNT_W     = $clog2(MAP_PAGES);
    localparam logic [PAGE_IN_W:0]  MAP_END   = (PAGE_IN_W + 1)'(MAP_PAGES);
    localparam logic [WADDR_W-1:0]  LAST_WORD = WADDR_W'(NUM_WORDS - 1);

    typedef enum logic [6:0] {
        ST_INIT    = 7'b0000001,
        ST_IDLE    = 7'b0000010,
        ST_ALLOC_RD = 7'b0000100,
        ST_SCAN    = 7'b0001000,
        ST_RMW_RD  = 7'b0010000,
        ST_RMW_WR  = 7'b0100000,
        ST_FINISH  = 7'b1000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        pip_reg, pip_next;
    logic [CNT_W-1:0]        want_reg, want_next;
    logic [CNT_W-1:0]        run_reg, run_next;
    logic [PW-1:0]           first_reg, first_next;
    logic [PW-1:0]           end_reg, end_next;
    logic [WADDR_W-1:0]      cur_word_reg, cur_word_next;
    logic [WADDR_W-1:0]      last_word_reg, last_word_next;
    logic                    fill_val_reg, fill_val_next;
    logic                    res_ok_reg, res_ok_next;
    logic [PW-1:0]           res_page_reg, res_page_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_success_reg, out_success_next;
    logic [OUT_PAGE_W-1:0]   out_page_reg, out_page_next;

    logic [WORD_W-1:0]       map_mem [NUM_WORDS];
    logic [WORD_W-1:0]       rd_data_reg;
    logic                    mem_we;
    logic [WADDR_W-1:0]      mem_waddr;
    logic [WADDR_W-1:0]      mem_raddr;
    logic [WORD_W-1:0]       mem_wdata;

    logic [PAGE_IN_W:0]      in_end;
    logic                    in_run_empty;
    logic [PW-1:0]           in_end_clamped;
    logic [PW-1:0]           in_end_m1;
    logic [PW-1:0]           pip_m1;

    logic [CNT_W-1:0]        scan_run;
    logic                    scan_hit;
    logic [PW-1:0]           scan_page;
    logic [PW-1:0]           scan_start;
    logic [WORD_W-1:0]       rmw_mask;
    logic [WORD_W-1:0]       rmw_wdata;
    logic [PW+OUT_PAGE_W-1:0] res_page_ext;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = out_valid_reg;
    assign m_success    = out_success_reg;
    assign m_alloc_page = out_page_reg;

    assign in_end       = {1'b0, s_start_page} + {1'b0, s_page_count};
    assign in_run_empty = (s_page_count == '0) || ({1'b0, s_start_page} >= MAP_END);
    assign in_end_clamped = (in_end > MAP_END) ? MAP_END[PW-1:0] : in_end[PW-1:0];
    assign in_end_m1    = in_end_clamped - PW'(1);
    assign pip_m1       = PW'(pip_reg) - PW'(1);
    assign scan_start   = scan_page + PW'(1) - PW'(want_reg);
    assign res_page_ext = (PW + OUT_PAGE_W)'(res_page_reg);

    always_comb begin
        logic [CNT_W-1:0] run;
        logic             hit;
        logic [PW-1:0]    hit_page;
        logic [PW-1:0]    pg;
        run      = run_reg;
        hit      = 1'b0;
        hit_page = '0;
        for (int b = 0; b < WORD_W; b++) begin
            pg = {1'b0, cur_word_reg, BIT_SEL_W'(b)};
            if (!hit && (pg != '0) && (pg < PW'(pip_reg))) begin
                if (rd_data_reg[b]) begin
                    run = '0;
                end else begin
                    run = run + CNT_W'(1);
                end
                if (run == want_reg) begin
                    hit      = 1'b1;
                    hit_page = pg;
                end
            end
        end
        scan_run  = run;
        scan_hit  = hit;
        scan_page = hit_page;
    end

    always_comb begin
        logic [PW-1:0] pg;
        for (int b = 0; b < WORD_W; b++) begin
            pg = {1'b0, cur_word_reg, BIT_SEL_W'(b)};
            rmw_mask[b] = (pg >= first_reg) && (pg < end_reg);
        end
        rmw_wdata = fill_val_reg ? (rd_data_reg | rmw_mask) : (rd_data_reg & ~rmw_mask);
    end

    always_comb begin
        state_next       = state_reg;
        pip_next         = pip_reg;
        want_next        = want_reg;
        run_next         = run_reg;
        first_next       = first_reg;
        end_next         = end_reg;
        cur_word_next    = cur_word_reg;
        last_word_next   = last_word_reg;
        fill_val_next    = fill_val_reg;
        res_ok_next      = res_ok_reg;
        res_page_next    = res_page_reg;
        out_valid_next   = out_valid_reg;
        out_success_next = out_success_reg;
        out_page_next    = out_page_reg;
        mem_we           = 1'b0;
        mem_waddr        = cur_word_reg;
        mem_wdata        = rmw_wdata;
        mem_raddr        = cur_word_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = WORD_ALL_USED;
                if (cur_word_reg == LAST_WORD) begin
                    state_next = ST_IDLE;
                end else begin
                    cur_word_next = cur_word_reg + WADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    res_ok_next    = 1'b1;
                    res_page_next  = '0;
                    run_next       = '0;
                    fill_val_next  = (op_t'(s_operation) == OP_MARK);
                    first_next     = s_start_page[PW-1:0];
                    end_next       = in_end_clamped;
                    cur_word_next  = s_start_page[WADDR_W+BIT_SEL_W-1:BIT_SEL_W];
                    last_word_next = in_end_m1[WADDR_W+BIT_SEL_W-1:BIT_SEL_W];
                    unique case (op_t'(s_operation))
                        OP_ALLOC: begin
                            if ((s_page_count == '0) || (s_page_count > PAGE_IN_W'(pip_reg))) begin
                                res_ok_next = 1'b0;
                                state_next  = ST_FINISH;
                            end else begin
                                want_next      = s_page_count[CNT_W-1:0];
                                cur_word_next  = '0;
                                last_word_next = pip_m1[WADDR_W+BIT_SEL_W-1:BIT_SEL_W];
                                state_next     = ST_ALLOC_RD;
                            end
                        end
                        OP_FREE, OP_MARK: begin
                            state_next = in_run_empty ? ST_FINISH : ST_RMW_RD;
                        end
                        OP_ADD: begin
                            if ((in_end > (PAGE_IN_W + 1)'(pip_reg)) && (in_end < MAP_END)) begin
                                pip_next = in_end[CNT_W-1:0];
                            end
                            if (is_usable(s_region_type) && !in_run_empty) begin
                                state_next = ST_RMW_RD;
                            end else begin
                                state_next = ST_FINISH;
                            end
                        end
                    endcase
                end
            end
            ST_ALLOC_RD: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                mem_raddr     = cur_word_reg + WADDR_W'(1);
                run_next      = scan_run;
                cur_word_next = cur_word_reg + WADDR_W'(1);
                if (scan_hit) begin
                    first_next     = scan_start;
                    end_next       = scan_page + PW'(1);
                    cur_word_next  = scan_start[WADDR_W+BIT_SEL_W-1:BIT_SEL_W];
                    last_word_next = scan_page[WADDR_W+BIT_SEL_W-1:BIT_SEL_W];
                    fill_val_next  = 1'b1;
                    res_page_next  = scan_start;
                    state_next     = ST_RMW_RD;
                end else if (cur_word_reg == last_word_reg) begin
                    res_ok_next = 1'b0;
                    state_next  = ST_FINISH;
                end
            end
            ST_RMW_RD: begin
                state_next = ST_RMW_WR;
            end
            ST_RMW_WR: begin
                mem_we    = 1'b1;
                mem_raddr = cur_word_reg + WADDR_W'(1);
                if (cur_word_reg == last_word_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    cur_word_next = cur_word_reg + WADDR_W'(1);
                end
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next   = 1'b1;
                    out_success_next = res_ok_reg;
                    out_page_next    = res_page_ext[OUT_PAGE_W-1:0];
                    state_next       = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= map_mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            pip_reg       <= '0;
            cur_word_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pip_reg       <= pip_next;
            cur_word_reg  <= cur_word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        want_reg        <= want_next;
        run_reg         <= run_next;
        first_reg       <= first_next;
        end_reg         <= end_next;
        last_word_reg   <= last_word_next;
        fill_val_reg    <= fill_val_next;
        res_ok_reg      <= res_ok_next;
        res_page_reg    <= res_page_next;
        out_success_reg <= out_success_next;
        out_page_reg    <= out_page_next;
    end

endmodule

FILE: src/bpa_checker.sv
// Port-level checks for the bitmap page allocator, bound to its top level.
module bpa_checker
    import bpa_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [OP_W-1:0]       s_operation,
    input logic [PAGE_IN_W-1:0]  s_start_page,
    input logic [PAGE_IN_W-1:0]  s_page_count,
    input logic [TYPE_W-1:0]     s_region_type,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_success,
    input logic [OUT_PAGE_W-1:0] m_alloc_page
);

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("ports not quiet after reset");

    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again before the item finished");

    a_fail_page_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_success |-> m_alloc_page == '0)
        else $error("failed alloc returned a nonzero page");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_success) && $stable(m_alloc_page))
        else $error("result dropped or changed while stalled");

endmodule

bind bitmap_page_allocator_unit bpa_checker u_bpa_checker (.*);
